// File: sv/smrc_pkg.sv
package smrc_pkg;

    localparam int MAX_RX_ANTENNAS = 8;
    localparam int CNT_W = $clog2(MAX_RX_ANTENNAS + 1);
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [35:0] POW_MAX = 36'hF_FFFF_FFFF;
    localparam logic signed [37:0] CROSS_MAX = 38'sh07_FFFF_FFFF;
    localparam logic signed [37:0] CROSS_MIN = -38'sh08_0000_0000;
    localparam logic [63:0] EST_POS_MAX = 64'd8388607;
    localparam logic [63:0] EST_NEG_MAX = 64'd8388608;
    localparam logic [63:0] U32_MAX = 64'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_CHAN = 2'd1,
        STATUS_ZERO_RX  = 2'd2,
        STATUS_TOO_MANY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_EST_RE = 3'd0,
        OP_EST_IM = 3'd1,
        OP_VAR    = 3'd2,
        OP_VD     = 3'd3,
        OP_TD     = 3'd4,
        OP_SINR   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQ1,
        ST_SQ2,
        ST_DSTART,
        ST_DWAIT,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic               too_many;
        logic [35:0]        pc;
        logic [35:0]        py;
        logic signed [35:0] cr;
        logic signed [35:0] ci;
    } job_t;

    typedef struct packed {
        logic        start;
        logic [15:0] hi;
        logic [63:0] lo;
        logic [63:0] den;
    } div_req_t;

endpackage

// File: sv/smrc_front.sv
module smrc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic signed [15:0]   chan_re,
    input  logic signed [15:0]   chan_im,
    input  logic signed [15:0]   rx_re,
    input  logic signed [15:0]   rx_im,
    input  logic                 last_antenna,
    output logic                 push,
    output smrc_pkg::job_t       job
);

    logic [smrc_pkg::CNT_W-1:0] cnt_reg;
    logic                       ovf_reg;
    logic                       room;

    logic                       p_valid_reg;
    logic                       p_sum_reg;
    logic                       p_last_reg;
    logic                       p_ovf_reg;
    logic signed [31:0]         p_hrhr_reg, p_hihi_reg, p_yryr_reg, p_yiyi_reg;
    logic signed [31:0]         p_hryr_reg, p_hiyi_reg, p_hryi_reg, p_hiyr_reg;

    logic [35:0]                pc_acc_reg, py_acc_reg;
    logic signed [35:0]         cr_acc_reg, ci_acc_reg;
    logic [37:0]                pc_sum, py_sum;
    logic signed [37:0]         cr_sum, ci_sum;
    logic [35:0]                pc_next, py_next;
    logic signed [35:0]         cr_next, ci_next;

    assign room = cnt_reg < smrc_pkg::CNT_W'(smrc_pkg::MAX_RX_ANTENNAS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= in_accept;
            if (in_accept) begin
                if (last_antenna) begin
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg + smrc_pkg::CNT_W'(room);
                    ovf_reg <= ovf_reg | ~room;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            p_sum_reg  <= room;
            p_last_reg <= last_antenna;
            p_ovf_reg  <= ovf_reg | ~room;
            p_hrhr_reg <= chan_re * chan_re;
            p_hihi_reg <= chan_im * chan_im;
            p_yryr_reg <= rx_re * rx_re;
            p_yiyi_reg <= rx_im * rx_im;
            p_hryr_reg <= chan_re * rx_re;
            p_hiyi_reg <= chan_im * rx_im;
            p_hryi_reg <= chan_re * rx_im;
            p_hiyr_reg <= chan_im * rx_re;
        end
    end

    always_comb begin
        pc_sum = {2'b0, pc_acc_reg} + {6'b0, p_hrhr_reg} + {6'b0, p_hihi_reg};
        py_sum = {2'b0, py_acc_reg} + {6'b0, p_yryr_reg} + {6'b0, p_yiyi_reg};
        cr_sum = 38'(cr_acc_reg) + 38'(p_hryr_reg) + 38'(p_hiyi_reg);
        ci_sum = 38'(ci_acc_reg) + 38'(p_hryi_reg) - 38'(p_hiyr_reg);
        if (p_sum_reg) begin
            pc_next = (pc_sum > {2'b0, smrc_pkg::POW_MAX}) ? smrc_pkg::POW_MAX : pc_sum[35:0];
            py_next = (py_sum > {2'b0, smrc_pkg::POW_MAX}) ? smrc_pkg::POW_MAX : py_sum[35:0];
            priority if (cr_sum > smrc_pkg::CROSS_MAX) begin
                cr_next = smrc_pkg::CROSS_MAX[35:0];
            end else if (cr_sum < smrc_pkg::CROSS_MIN) begin
                cr_next = smrc_pkg::CROSS_MIN[35:0];
            end else begin
                cr_next = cr_sum[35:0];
            end
            priority if (ci_sum > smrc_pkg::CROSS_MAX) begin
                ci_next = smrc_pkg::CROSS_MAX[35:0];
            end else if (ci_sum < smrc_pkg::CROSS_MIN) begin
                ci_next = smrc_pkg::CROSS_MIN[35:0];
            end else begin
                ci_next = ci_sum[35:0];
            end
        end else begin
            pc_next = pc_acc_reg;
            py_next = py_acc_reg;
            cr_next = cr_acc_reg;
            ci_next = ci_acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_acc_reg <= '0;
            py_acc_reg <= '0;
            cr_acc_reg <= '0;
            ci_acc_reg <= '0;
        end else if (p_valid_reg) begin
            if (p_last_reg) begin
                pc_acc_reg <= '0;
                py_acc_reg <= '0;
                cr_acc_reg <= '0;
                ci_acc_reg <= '0;
            end else begin
                pc_acc_reg <= pc_next;
                py_acc_reg <= py_next;
                cr_acc_reg <= cr_next;
                ci_acc_reg <= ci_next;
            end
        end
    end

    assign push         = p_valid_reg & p_last_reg;
    assign job.too_many = p_ovf_reg;
    assign job.pc       = pc_next;
    assign job.py       = py_next;
    assign job.cr       = cr_next;
    assign job.ci       = ci_next;

endmodule

// File: sv/smrc_fifo.sv
module smrc_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  smrc_pkg::job_t                push_data,
    input  logic                          pop,
    output logic                          not_empty,
    output smrc_pkg::job_t                pop_data,
    output logic [smrc_pkg::QCNT_W-1:0]   count
);

    smrc_pkg::job_t                 mem_reg [smrc_pkg::QDEPTH];
    logic [smrc_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [smrc_pkg::QCNT_W-1:0]    count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + smrc_pkg::QCNT_W'(push) - smrc_pkg::QCNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// File: sv/smrc_div.sv
module smrc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  smrc_pkg::div_req_t  req,
    output logic                done,
    output logic [63:0]         quot
);

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] rem_reg, lo_reg, q_reg;
    logic [63:0] q_den_reg;
    logic [64:0] rem2, diff;
    logic        ge;

    assign rem2 = {rem_reg, lo_reg[63]};
    assign diff = rem2 - {1'b0, q_den_reg};
    assign ge   = rem2 >= {1'b0, q_den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                if ({48'b0, req.hi} >= req.den) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 7'd64;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            q_den_reg <= req.den;
            rem_reg   <= {48'b0, req.hi};
            lo_reg    <= req.lo;
            q_reg     <= ({48'b0, req.hi} >= req.den) ? '1 : '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[63:0] : rem2[63:0];
            lo_reg  <= {lo_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: sv/smrc_back.sv
module smrc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          noise_std,
    input  logic [12:0]          carrier_count,
    input  logic                 job_valid,
    input  smrc_pkg::job_t       job,
    output logic                 job_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [23:0]   est_re,
    output logic signed [23:0]   est_im,
    output logic [31:0]          est_variance,
    output logic [31:0]          sinr,
    output logic [1:0]           status
);

    smrc_pkg::back_state_t state_reg, state_next;
    smrc_pkg::op_t         op_reg;
    smrc_pkg::job_t        job_reg;
    smrc_pkg::status_t     status_reg, status_comb;
    smrc_pkg::div_req_t    req;

    logic [31:0]        s2_reg;
    logic [63:0]        s4_reg;
    logic [48:0]        pycc_reg;
    logic [63:0]        vd_reg, td_reg;
    logic [64:0]        dsum;
    logic [63:0]        dsat;
    logic               div_done;
    logic [63:0]        quot;
    logic [12:0]        cc;
    logic               neg_re, neg_im;
    logic [35:0]        mag_re, mag_im;
    logic [63:0]        est_pos, est_neg;
    logic signed [23:0] est_re_reg, est_im_reg;
    logic [31:0]        var_reg, sinr_reg;
    logic               last_op;

    assign cc     = (carrier_count == '0) ? 13'd1 : carrier_count;
    assign neg_re = job_reg.cr[35];
    assign neg_im = job_reg.ci[35];
    assign mag_re = neg_re ? 36'(-job_reg.cr) : job_reg.cr;
    assign mag_im = neg_im ? 36'(-job_reg.ci) : job_reg.ci;
    assign dsum   = {1'b0, vd_reg} + {1'b0, td_reg};
    assign dsat   = dsum[64] ? '1 : dsum[63:0];
    assign est_pos = (quot > smrc_pkg::EST_POS_MAX) ? smrc_pkg::EST_POS_MAX : quot;
    assign est_neg = (quot > smrc_pkg::EST_NEG_MAX) ? smrc_pkg::EST_NEG_MAX : quot;
    assign last_op = op_reg == smrc_pkg::OP_SINR;

    always_comb begin
        priority if (job_reg.too_many) begin
            status_comb = smrc_pkg::STATUS_TOO_MANY;
        end else if (job_reg.pc == '0) begin
            status_comb = smrc_pkg::STATUS_ZERO_CHAN;
        end else if (job_reg.py == '0) begin
            status_comb = smrc_pkg::STATUS_ZERO_RX;
        end else begin
            status_comb = smrc_pkg::STATUS_OK;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smrc_pkg::ST_IDLE:   if (job_valid) state_next = smrc_pkg::ST_CHECK;
            smrc_pkg::ST_CHECK: begin
                state_next = (status_comb == smrc_pkg::STATUS_OK) ? smrc_pkg::ST_SQ1
                                                                   : smrc_pkg::ST_OUT;
            end
            smrc_pkg::ST_SQ1:    state_next = smrc_pkg::ST_SQ2;
            smrc_pkg::ST_SQ2:    state_next = smrc_pkg::ST_DSTART;
            smrc_pkg::ST_DSTART: begin
                if (last_op && dsat == '0) begin
                    state_next = smrc_pkg::ST_OUT;
                end else begin
                    state_next = smrc_pkg::ST_DWAIT;
                end
            end
            smrc_pkg::ST_DWAIT: begin
                if (div_done) begin
                    state_next = last_op ? smrc_pkg::ST_OUT : smrc_pkg::ST_DSTART;
                end
            end
            smrc_pkg::ST_OUT:    if (m_ready) state_next = smrc_pkg::ST_IDLE;
            default:             state_next = smrc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        job_pop   = (state_reg == smrc_pkg::ST_IDLE) && job_valid;
        m_valid   = state_reg == smrc_pkg::ST_OUT;
        req.start = (state_reg == smrc_pkg::ST_DSTART) && !(last_op && dsat == '0);
        req.hi    = '0;
        req.lo    = '0;
        req.den   = {28'b0, job_reg.pc};
        unique case (op_reg)
            smrc_pkg::OP_EST_RE: req.lo = {13'b0, mag_re, 15'b0} + {29'b0, job_reg.pc[35:1]};
            smrc_pkg::OP_EST_IM: req.lo = {13'b0, mag_im, 15'b0} + {29'b0, job_reg.pc[35:1]};
            smrc_pkg::OP_VAR:    req.lo = {12'b0, s2_reg, 20'b0} + {29'b0, job_reg.pc[35:1]};
            smrc_pkg::OP_VD: begin
                req.hi = {12'b0, s2_reg[31:28]};
                req.lo = {s2_reg[27:0], 36'b0};
            end
            smrc_pkg::OP_TD: begin
                req.hi  = {2'b0, s4_reg[63:50]};
                req.lo  = {s4_reg[49:0], 14'b0};
                req.den = {15'b0, pycc_reg};
            end
            smrc_pkg::OP_SINR: begin
                req.lo  = (64'd1 << 48) + {1'b0, dsat[63:1]};
                req.den = dsat;
            end
            default: begin
                req.lo = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smrc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            smrc_pkg::ST_IDLE: begin
                if (job_valid) job_reg <= job;
            end
            smrc_pkg::ST_CHECK: begin
                status_reg <= status_comb;
                op_reg     <= smrc_pkg::OP_EST_RE;
                est_re_reg <= '0;
                est_im_reg <= '0;
                var_reg    <= '0;
                sinr_reg   <= '0;
            end
            smrc_pkg::ST_SQ1: begin
                s2_reg   <= noise_std * noise_std;
                pycc_reg <= job_reg.py * cc;
            end
            smrc_pkg::ST_SQ2: begin
                s4_reg <= s2_reg * s2_reg;
            end
            smrc_pkg::ST_DSTART: begin
                if (last_op && dsat == '0) sinr_reg <= smrc_pkg::U32_MAX[31:0];
            end
            smrc_pkg::ST_DWAIT: begin
                if (div_done) begin
                    unique case (op_reg)
                        smrc_pkg::OP_EST_RE: est_re_reg <= neg_re ? 24'(-est_neg)
                                                                  : est_pos[23:0];
                        smrc_pkg::OP_EST_IM: est_im_reg <= neg_im ? 24'(-est_neg)
                                                                  : est_pos[23:0];
                        smrc_pkg::OP_VAR:    var_reg <= (quot > smrc_pkg::U32_MAX) ? '1
                                                                                  : quot[31:0];
                        smrc_pkg::OP_VD:     vd_reg <= quot;
                        smrc_pkg::OP_TD:     td_reg <= quot;
                        smrc_pkg::OP_SINR:   sinr_reg <= (quot > smrc_pkg::U32_MAX) ? '1
                                                                                   : quot[31:0];
                        default:             vd_reg <= quot;
                    endcase
                    if (!last_op) op_reg <= smrc_pkg::op_t'(op_reg + 3'd1);
                end
            end
            smrc_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    smrc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .done    (div_done),
        .quot    (quot)
    );

    assign est_re       = est_re_reg;
    assign est_im       = est_im_reg;
    assign est_variance = var_reg;
    assign sinr         = sinr_reg;
    assign status       = status_reg;

endmodule

// File: sv/single_layer_mrc_equalizer.sv
// Single-layer maximum ratio combining equalizer.
// Input channel (s_valid/s_ready): one transaction per receive antenna with the
// channel coefficient and received sample; s_last_antenna closes a subcarrier.
// Result channel (m_valid/m_ready): one transaction per closed subcarrier with
// the symbol estimate, its variance, the SINR and a status code.
// Configuration: cfg_we with cfg_index 0 writes noise_std, index 1 carrier_count.
// Throughput: the front takes one antenna transaction per cycle while fewer
// than three jobs wait in its four-entry queue; the front has a product stage
// and an accumulate stage.
// The back end runs up to six 64-step divisions on one shared restoring
// divider, where a quotient that would overflow saturates at once, and that
// sets the sustained subcarrier rate.
// Reset clears the sums and the queue, returns the back end to idle, and loads
// noise_std to 1.0 and carrier_count to 1.
// A stalled receiver holds the result in the output register; the front keeps
// accepting until three jobs wait in the queue, then drops s_ready.
module single_layer_mrc_equalizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_chan_re,
    input  logic signed [15:0]  s_chan_im,
    input  logic signed [15:0]  s_rx_re,
    input  logic signed [15:0]  s_rx_im,
    input  logic                s_last_antenna,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [23:0]  m_est_re,
    output logic signed [23:0]  m_est_im,
    output logic [31:0]         m_est_variance,
    output logic [31:0]         m_sinr,
    output logic [1:0]          m_status
);

    localparam logic CFG_NOISE_STD = 1'b0;
    localparam logic CFG_CARRIERS  = 1'b1;

    logic [15:0]                   noise_std_reg;
    logic [12:0]                   carrier_count_reg;
    logic                          push, pop, q_valid, in_accept;
    smrc_pkg::job_t                push_job, pop_job;
    logic [smrc_pkg::QCNT_W-1:0]   q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_std_reg     <= 16'd4096;
            carrier_count_reg <= 13'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NOISE_STD: noise_std_reg     <= cfg_data;
                CFG_CARRIERS:  carrier_count_reg <= cfg_data[12:0];
                default:       noise_std_reg     <= noise_std_reg;
            endcase
        end
    end

    assign s_ready   = q_count < smrc_pkg::QCNT_W'(smrc_pkg::QDEPTH - 1);
    assign in_accept = s_valid & s_ready;

    smrc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .chan_re      (s_chan_re),
        .chan_im      (s_chan_im),
        .rx_re        (s_rx_re),
        .rx_im        (s_rx_im),
        .last_antenna (s_last_antenna),
        .push         (push),
        .job          (push_job)
    );

    smrc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_data  (pop_job),
        .count     (q_count)
    );

    smrc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .noise_std     (noise_std_reg),
        .carrier_count (carrier_count_reg),
        .job_valid     (q_valid),
        .job           (pop_job),
        .job_pop       (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .est_re        (m_est_re),
        .est_im        (m_est_im),
        .est_variance  (m_est_variance),
        .sinr          (m_sinr),
        .status        (m_status)
    );

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= smrc_pkg::QCNT_W'(smrc_pkg::QDEPTH))
        else $error("job queue overflow");

    a_bad_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != smrc_pkg::STATUS_OK) |->
        (m_est_re == '0 && m_est_im == '0 && m_est_variance == '0 && m_sinr == '0))
        else $error("nonzero status with nonzero outputs");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count == smrc_pkg::QCNT_W'(smrc_pkg::QDEPTH)) |-> !push)
        else $error("push into full queue");
`endif

endmodule

// File: verif/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REG_NOISE_STD = 1'b0;
    localparam logic REG_CARRIER_COUNT = 1'b1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 600;

    typedef struct {
        logic signed [23:0]  est_re;
        logic signed [23:0]  est_im;
        logic [31:0]         est_variance;
        logic [31:0]         sinr;
        smrc_pkg::status_t   status;
    } mrc_result_t;

    class mrc_scoreboard;
        logic [15:0]   noise_std;
        logic [12:0]   carrier_count;
        int            antennas;
        bit            overflow;
        longint        chan_pow;
        longint        rx_pow;
        longint        cross_re;
        longint        cross_im;
        mrc_result_t   expected_q[$];
        int            errors;
        int            results_seen;
        int            status_seen[4];

        function new();
            noise_std = 16'd4096;
            carrier_count = 13'd1;
            errors = 0;
            results_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            antennas = 0;
            overflow = 0;
            chan_pow = 0;
            rx_pow = 0;
            cross_re = 0;
            cross_im = 0;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function logic [63:0] div_sat(logic [127:0] num, logic [127:0] den);
            logic [127:0] q;
            q = num / den;
            return (q > 128'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
        endfunction

        function logic signed [23:0] round_est(longint num, longint den);
            longint mag;
            longint q;
            mag = num < 0 ? -num : num;
            q = ((mag <<< 15) + den / 2) / den;
            if (num < 0)
                return (q > 8388608) ? -24'sd8388608 : 24'(-q);
            return (q > 8388607) ? 24'sd8388607 : 24'(q);
        endfunction

        function void note_input(logic signed [15:0] hr, logic signed [15:0] hi,
                                 logic signed [15:0] yr, logic signed [15:0] yi,
                                 logic last);
            longint lhr, lhi, lyr, lyi;
            mrc_result_t r;
            logic [127:0] s2, s4, pc, py, cc, vd, td, d, sn;
            lhr = 64'(hr); lhi = 64'(hi); lyr = 64'(yr); lyi = 64'(yi);
            if (antennas >= smrc_pkg::MAX_RX_ANTENNAS) begin
                overflow = 1;
            end else begin
                chan_pow = clamp(chan_pow + lhr * lhr + lhi * lhi, 0, 64'hF_FFFF_FFFF);
                rx_pow = clamp(rx_pow + lyr * lyr + lyi * lyi, 0, 64'hF_FFFF_FFFF);
                cross_re = clamp(cross_re + lhr * lyr + lhi * lyi,
                                 -64'sh8_0000_0000, 64'sh7_FFFF_FFFF);
                cross_im = clamp(cross_im + lhr * lyi - lhi * lyr,
                                 -64'sh8_0000_0000, 64'sh7_FFFF_FFFF);
                antennas++;
            end
            if (!last)
                return;
            r.est_re = '0;
            r.est_im = '0;
            r.est_variance = '0;
            r.sinr = '0;
            if (overflow)
                r.status = smrc_pkg::STATUS_TOO_MANY;
            else if (chan_pow == 0)
                r.status = smrc_pkg::STATUS_ZERO_CHAN;
            else if (rx_pow == 0)
                r.status = smrc_pkg::STATUS_ZERO_RX;
            else
                r.status = smrc_pkg::STATUS_OK;
            if (r.status == smrc_pkg::STATUS_OK) begin
                pc = 128'(chan_pow);
                py = 128'(rx_pow);
                cc = (carrier_count == 0) ? 128'd1 : 128'(carrier_count);
                s2 = 128'(noise_std) * 128'(noise_std);
                s4 = s2 * s2;
                r.est_re = round_est(cross_re, chan_pow);
                r.est_im = round_est(cross_im, chan_pow);
                d = ((s2 << 20) + pc / 2) / pc;
                r.est_variance = (d > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
                vd = 128'(div_sat(s2 << 36, pc));
                td = 128'(div_sat(s4 << 14, py * cc));
                d = vd + td;
                if (d > 128'hFFFF_FFFF_FFFF_FFFF)
                    d = 128'hFFFF_FFFF_FFFF_FFFF;
                if (d == 0) begin
                    r.sinr = 32'hFFFF_FFFF;
                end else begin
                    sn = ((128'd1 << 48) + d / 2) / d;
                    r.sinr = (sn > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : sn[31:0];
                end
            end
            expected_q.push_back(r);
            clear_sums();
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v,
                         act_v);
                errors++;
            end
        endfunction

        function void check_result(mrc_result_t act);
            mrc_result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d",
                         $time, act.status);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            results_seen++;
            status_seen[e.status]++;
            compare("est_re", 32'(e.est_re), 32'(act.est_re));
            compare("est_im", 32'(e.est_im), 32'(act.est_im));
            compare("est_variance", e.est_variance, act.est_variance);
            compare("sinr", e.sinr, act.sinr);
            compare("status", 32'(e.status), 32'(act.status));
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_we = 0;
    logic               cfg_index = 0;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [15:0] s_chan_re = '0;
    logic signed [15:0] s_chan_im = '0;
    logic signed [15:0] s_rx_re = '0;
    logic signed [15:0] s_rx_im = '0;
    logic               s_last_antenna = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [23:0] m_est_re;
    logic signed [23:0] m_est_im;
    logic [31:0]        m_est_variance;
    logic [31:0]        m_sinr;
    logic [1:0]         m_status;

    mrc_scoreboard sb = new();
    int  cycles = 0;
    int  items_sent = 0;
    bit  no_gaps = 0;

    single_layer_mrc_equalizer uut (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        mrc_result_t act;
        int gap;
        wait (aresetn);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            act.est_re = m_est_re;
            act.est_im = m_est_im;
            act.est_variance = m_est_variance;
            act.sinr = m_sinr;
            act.status = smrc_pkg::status_t'(m_status);
            sb.check_result(act);
        end
    end

    task automatic send_antenna(logic [15:0] hr, logic [15:0] hi, logic [15:0] yr,
                                logic [15:0] yi, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_chan_re <= hr;
        s_chan_im <= hi;
        s_rx_re <= yr;
        s_rx_im <= yi;
        s_last_antenna <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(hr, hi, yr, yi, last);
        items_sent++;
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        s_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
        if (idx == REG_NOISE_STD)
            sb.noise_std = val;
        else
            sb.carrier_count = val[12:0];
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_subcarrier();
        int n;
        bit zero_h, zero_y;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        zero_h = $urandom_range(0, 11) == 0;
        zero_y = $urandom_range(0, 11) == 0;
        for (int i = 0; i < n; i++)
            send_antenna(zero_h ? 16'h0 : rand_sample(), zero_h ? 16'h0 : rand_sample(),
                         zero_y ? 16'h0 : rand_sample(), zero_y ? 16'h0 : rand_sample(),
                         i == n - 1);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_antenna(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 1);
        send_antenna(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 1);
        send_antenna(16'h0000, 16'h0000, 16'h0001, 16'h0000, 1);
        send_antenna(16'h0001, 16'h0000, 16'h0000, 16'h0000, 1);
        for (int i = 0; i < 10; i++)
            send_antenna(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), i == 9);
        for (int i = 0; i < 8; i++)
            send_antenna(16'h8000, 16'h8000, 16'h8000, 16'h8000, i == 7);

        write_reg(REG_NOISE_STD, 16'd0);
        write_reg(REG_CARRIER_COUNT, 16'd4096);
        send_antenna(16'h4000, 16'h0000, 16'h4000, 16'h0000, 1);
        write_reg(REG_NOISE_STD, 16'hFFFF);
        write_reg(REG_CARRIER_COUNT, 16'd1);
        send_antenna(16'h0001, 16'h0000, 16'h0001, 16'h0000, 1);
        write_reg(REG_CARRIER_COUNT, 16'd0);
        send_antenna(16'h0100, 16'hFF00, 16'h0010, 16'h0020, 1);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_NOISE_STD, 16'd4096);
                    write_reg(REG_CARRIER_COUNT, 16'd1);
                end
                1: begin
                    write_reg(REG_NOISE_STD, 16'd1);
                    write_reg(REG_CARRIER_COUNT, 16'h1FFF);
                end
                2: begin
                    write_reg(REG_NOISE_STD, 16'hFFFF);
                    write_reg(REG_CARRIER_COUNT, 16'd4096);
                end
                3: begin
                    write_reg(REG_NOISE_STD, 16'd0);
                    write_reg(REG_CARRIER_COUNT, 16'd1);
                end
                default: begin
                    write_reg(REG_NOISE_STD, 16'($urandom));
                    write_reg(REG_CARRIER_COUNT, 16'($urandom_range(1, 4096)));
                end
            endcase
            no_gaps = (phase % 3) == 1;
            while (items_sent < 25 + 72 * (phase + 1))
                send_subcarrier();
        end
        no_gaps = 0;
        s_valid <= 0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d antenna transactions, %0d results (ok %0d, zero channel %0d,",
                 items_sent, sb.results_seen, sb.status_seen[0], sb.status_seen[1]);
        $display("zero rx %0d, too many antennas %0d) over several noise/carrier settings",
                 sb.status_seen[2], sb.status_seen[3]);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/smrc_pkg.sv
sv/smrc_front.sv
sv/smrc_fifo.sv
sv/smrc_div.sv
sv/smrc_back.sv
sv/single_layer_mrc_equalizer.sv
verif/testbench.sv
